// ----- design/bmtc_pkg.sv -----
// Package: shared widths and defaults for the bit matrix transitive closure block.
`timescale 1ns / 1ps

package bmtc_pkg;

    localparam int ROW_W        = 32;  // bits in one adjacency row
    localparam int IDX_W        = 5;   // row index field width
    localparam int CNT_W        = 6;   // node_count register width
    localparam int TDATA_W      = 40;  // index + row, padded to whole bytes
    localparam int NODES_DEF    = 32;
    localparam int NODE_CNT_RST = 32;

endpackage

// ----- design/bit_matrix_transitive_closure_top.sv -----
// Top level: Warshall transitive closure over a bit-matrix row store.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: row_index, row_bits; tlast: last_row
//  m_      | out | m_tvalid/m_tready  | tdata: out_row_index, reach_bits; tlast: out_last
//  cfg_    | in  | cfg_we             | cfg_wdata: node_count
//
// A row whose index lies inside the store is written to the row store. The last
// row also starts the closure: for each pivot the pivot row is read and captured,
// then every active row is read, updated and written back through the row store;
// then each result row is read from memory and loaded, waiting on any output stall.
// s_tready is low from the last row until the final result is loaded.
// Reset (aresetn low, synchronous) clears all row valid bits and the control.
`timescale 1ns / 1ps

module bit_matrix_transitive_closure_top #(
    parameter int NODES = bmtc_pkg::NODES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [bmtc_pkg::CNT_W-1:0]   cfg_wdata,   // node_count
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bmtc_pkg::TDATA_W-1:0] s_tdata,     // [4:0] row_index, [36:5] row_bits
    input  logic                         s_tlast,     // last_row
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bmtc_pkg::TDATA_W-1:0] m_tdata,     // [4:0] out_row_index, [36:5] reach_bits
    output logic                         m_tlast      // out_last
);
    import bmtc_pkg::*;

    localparam int STORE_ROWS = (NODES < ROW_W) ? NODES : ROW_W;
    localparam int AW         = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PIVOT,
        ST_PCAP,
        ST_ROW,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   node_count_reg;
    logic [AW-1:0]      k_reg, k_next;
    logic [AW-1:0]      i_reg, i_next;
    logic [AW-1:0]      nlast_reg, nlast_next;
    logic [ROW_W-1:0]   mask_reg, mask_next;
    logic [ROW_W-1:0]   pivot_reg, pivot_next;
    logic               m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]   m_index_reg, m_index_next;
    logic [ROW_W-1:0]   m_bits_reg, m_bits_next;
    logic               m_last_reg, m_last_next;

    // row store
    logic [ROW_W-1:0]      mem [STORE_ROWS];
    logic [STORE_ROWS-1:0] vld_reg;
    logic [ROW_W-1:0]      rd_data_reg;
    logic                  rd_vld_reg;
    logic                  rd_en, wr_en, clr_all;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic [ROW_W-1:0]      wr_data;

    logic               s_accept;
    logic [IDX_W-1:0]   s_idx;
    logic [ROW_W-1:0]   s_bits;
    logic [CNT_W-1:0]   n_m1;
    logic [ROW_W-1:0]   row_m;
    logic               out_free;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign s_idx    = s_tdata[IDX_W-1:0];
    assign s_bits   = s_tdata[IDX_W +: ROW_W];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W - IDX_W - ROW_W){1'b0}}, m_bits_reg, m_index_reg};
    assign m_tlast  = m_last_reg;

    // rows never written read as empty; bits beyond the graph drop out
    assign row_m    = (rd_vld_reg ? rd_data_reg : '0) & mask_reg;
    assign out_free = !m_valid_reg || m_tready;

    // highest active node index from the register, clamped to the store
    always_comb begin
        if (node_count_reg == '0) begin
            n_m1 = '0;
        end else if (node_count_reg > CNT_W'(STORE_ROWS)) begin
            n_m1 = CNT_W'(STORE_ROWS - 1);
        end else begin
            n_m1 = node_count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        nlast_next   = nlast_reg;
        mask_next    = mask_reg;
        pivot_next   = pivot_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_index_next = m_index_reg;
        m_bits_next  = m_bits_reg;
        m_last_next  = m_last_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        clr_all      = 1'b0;

        case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    if ({1'b0, s_idx} < (IDX_W + 1)'(STORE_ROWS)) begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(s_idx);
                        wr_data = s_bits;
                    end
                    if (s_tlast) begin
                        nlast_next = AW'(n_m1);
                        for (int j = 0; j < ROW_W; j++) begin
                            mask_next[j] = (CNT_W'(j) <= n_m1);
                        end
                        k_next     = '0;
                        state_next = ST_PIVOT;
                    end
                end
            end
            ST_PIVOT: begin
                rd_en      = 1'b1;
                rd_addr    = k_reg;
                state_next = ST_PCAP;
            end
            ST_PCAP: begin
                pivot_next = row_m;
                rd_en      = 1'b1;
                rd_addr    = '0;
                i_next     = '0;
                state_next = ST_ROW;
            end
            ST_ROW: begin
                // row i_reg arrives; write it back while the next row is read
                wr_en   = 1'b1;
                wr_addr = i_reg;
                wr_data = row_m | (row_m[IDX_W'(k_reg)] ? pivot_reg : '0);
                if (i_reg == nlast_reg) begin
                    if (k_reg == nlast_reg) begin
                        i_next     = '0;
                        state_next = ST_EMIT_RD;
                    end else begin
                        k_next     = k_reg + AW'(1);
                        state_next = ST_PIVOT;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = i_reg + AW'(1);
                    i_next  = i_reg + AW'(1);
                end
            end
            ST_EMIT_RD: begin
                rd_en      = 1'b1;
                rd_addr    = i_reg;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                // read data holds until the output register frees up
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_index_next = IDX_W'(i_reg);
                    m_bits_next  = row_m;
                    m_last_next  = (i_reg == nlast_reg);
                    if (i_reg == nlast_reg) begin
                        clr_all    = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        i_next     = i_reg + AW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            node_count_reg <= CNT_W'(NODE_CNT_RST);
            m_valid_reg    <= 1'b0;
            k_reg          <= '0;
            i_reg          <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            k_reg       <= k_next;
            i_reg       <= i_next;
            if (cfg_we) begin
                node_count_reg <= cfg_wdata;
            end
        end
        nlast_reg   <= nlast_next;
        mask_reg    <= mask_next;
        pivot_reg   <= pivot_next;
        m_index_reg <= m_index_next;
        m_bits_reg  <= m_bits_next;
        m_last_reg  <= m_last_next;
    end

    // row store: one write port, one registered read port, per-row valid bits
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (clr_all) begin
                vld_reg <= '0;
            end else if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

endmodule

// ----- test/tb_bit_matrix_transitive_closure_top.sv -----
// Testbench: random and directed graphs through the transitive closure block, checked row by row.
`timescale 1ns / 1ps

module tb_bit_matrix_transitive_closure_top;
    import bmtc_pkg::*;

    localparam int TARGET_ITEMS  = 230;
    localparam int QUIET_ITEMS   = 30;     // final items sent with no idling
    localparam int SETTLE_CYCLES = 40;     // pad after drain before a register write
    localparam int LONG_HOLD     = 400;    // receiver hold-off, fills the block
    localparam int STALL_LIMIT   = 20000;  // cycles with no handshake before giving up
    localparam int STORE_ROWS    = (NODES_DEF < 32) ? NODES_DEF : 32;

    typedef struct packed {
        logic [IDX_W-1:0] node;
        logic [ROW_W-1:0] reach;
        logic             last;
    } reach_row_t;

    // Warshall predictor plus queue of closure rows still owed by the block
    class closure_scoreboard;
        logic [ROW_W-1:0] adj_rows [STORE_ROWS];
        logic [CNT_W-1:0] node_count;
        reach_row_t       owed_rows [$];
        int errors;
        int rows_loaded;
        int rows_checked;
        int graphs_closed;

        function new();
            foreach (adj_rows[i]) adj_rows[i] = '0;
            node_count    = CNT_W'(NODE_CNT_RST);
            errors        = 0;
            rows_loaded   = 0;
            rows_checked  = 0;
            graphs_closed = 0;
        endfunction

        function void set_node_count(logic [CNT_W-1:0] value);
            node_count = value;
        endfunction

        function int pending();
            return owed_rows.size();
        endfunction

        function void note_row(logic [IDX_W-1:0] idx, logic [ROW_W-1:0] bits, logic last);
            int n;
            logic [ROW_W-1:0] mask;
            logic [ROW_W-1:0] pivot;
            reach_row_t row;
            rows_loaded++;
            if (int'(idx) < STORE_ROWS) adj_rows[idx] = bits;
            if (!last) return;
            n = int'(node_count);
            if (n < 1) n = 1;
            if (n > STORE_ROWS) n = STORE_ROWS;
            mask = (n >= 32) ? '1 : ((ROW_W'(1) << n) - 1);
            for (int i = 0; i < n; i++) adj_rows[i] &= mask;
            for (int k = 0; k < n; k++) begin
                pivot = adj_rows[k];
                for (int i = 0; i < n; i++) begin
                    if (adj_rows[i][k]) adj_rows[i] |= pivot;
                end
            end
            for (int i = 0; i < n; i++) begin
                row.node  = IDX_W'(i);
                row.reach = adj_rows[i];
                row.last  = (i == n - 1);
                owed_rows.insert(owed_rows.size(), row);
            end
            foreach (adj_rows[i]) adj_rows[i] = '0;
            graphs_closed++;
        endfunction

        function void check_row(logic [IDX_W-1:0] node, logic [ROW_W-1:0] reach, logic last);
            reach_row_t want;
            if (owed_rows.size() == 0) begin
                $error("closure row with nothing owed: node %0d reach %h", node, reach);
                errors++;
                return;
            end
            want = owed_rows.pop_front();
            rows_checked++;
            if (node !== want.node) begin
                $error("out_row_index: expected %0d, got %0d", want.node, node);
                errors++;
            end
            if (reach !== want.reach) begin
                $error("reach_bits: expected %h, got %h", want.reach, reach);
                errors++;
            end
            if (last !== want.last) begin
                $error("out_last: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [CNT_W-1:0]   cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;    // [4:0] row_index, [36:5] row_bits
    logic               s_tlast;    // last_row
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;    // [4:0] out_row_index, [36:5] reach_bits
    logic               m_tlast;    // out_last

    closure_scoreboard sb;
    bit quiet;
    bit long_hold_req;
    int items_sent;
    int stall_cycles;

    bit_matrix_transitive_closure_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_row(m_tdata[IDX_W-1:0], m_tdata[IDX_W +: ROW_W], m_tlast);
    end

    // no-progress watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("[bit_matrix_transitive_closure_top] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin : rx_side
        int gap;
        m_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 7);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_row(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] bits,
                            input logic last);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W - IDX_W - ROW_W){1'b0}}, bits, idx};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_row(idx, bits, last);
        items_sent++;
    endtask

    // stop offering and wait until every owed closure row is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_node_count(input logic [CNT_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_node_count(value);
    endtask

    // one graph: a few rows, mostly inside the active nodes, last one closes it
    task automatic random_graph(input int n, input bit hold_on_last);
        int rows;
        logic [IDX_W-1:0] idx;
        logic [ROW_W-1:0] bits;
        rows = $urandom_range(1, (n + 1 < 12) ? n + 1 : 12);
        for (int r = 0; r < rows; r++) begin
            if ($urandom_range(0, 7) == 0)
                idx = IDX_W'($urandom_range(0, 31));
            else
                idx = IDX_W'($urandom_range(0, n - 1));
            case ($urandom_range(0, 3))
                0: bits = $urandom;
                1: bits = ROW_W'(1) << $urandom_range(0, n - 1);
                default: bits = $urandom & $urandom & $urandom;
            endcase
            if (hold_on_last && r == rows - 1) long_hold_req = 1'b1;
            send_row(idx, bits, r == rows - 1);
        end
    endtask

    initial begin : main
        int n;
        int graph_no;
        logic [CNT_W-1:0] count_val;
        sb            = new();
        quiet         = 1'b0;
        long_hold_req = 1'b0;
        items_sent    = 0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset count of 32: a three-node cycle through the top index
        send_row(5'd5, 32'h0000_0001, 1'b0);
        send_row(5'd0, 32'h8000_0000, 1'b0);
        send_row(5'd31, 32'h0000_0020, 1'b1);
        send_row(5'd0, 32'hFFFF_FFFF, 1'b1);

        // four nodes: ring, overwritten row, stray bits and an out-of-range row
        write_node_count(6'd4);
        send_row(5'd0, 32'h0000_0002, 1'b0);
        send_row(5'd1, 32'h0000_0004, 1'b0);
        send_row(5'd2, 32'hFFFF_FFF0, 1'b0);
        send_row(5'd2, 32'h0000_0008, 1'b0);
        send_row(5'd20, 32'h0000_000F, 1'b0);
        send_row(5'd3, 32'hFFFF_FFF1, 1'b1);

        // zero count acts as one node; closure is not reflexive
        write_node_count(6'd0);
        send_row(5'd0, 32'hFFFF_FFFF, 1'b1);
        send_row(5'd0, 32'h0000_0000, 1'b1);

        // count above the store clamps to 32
        write_node_count(6'd63);
        send_row(5'd10, 32'hFFFF_FFFF, 1'b0);
        send_row(5'd31, 32'h0000_0000, 1'b1);

        // last flag on a row outside the graph: all rows empty, then a loop between nodes 0 and 1
        write_node_count(6'd3);
        send_row(5'd20, 32'hFFFF_FFFF, 1'b1);
        send_row(5'd0, 32'h0000_0002, 1'b0);
        send_row(5'd1, 32'h0000_0001, 1'b0);
        send_row(5'd2, 32'h0000_0004, 1'b1);

        n = 3;
        graph_no = 0;
        while (items_sent < TARGET_ITEMS) begin
            if (items_sent >= TARGET_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            if (graph_no % 3 == 0) begin
                if (graph_no == 3) begin
                    count_val = CNT_W'($urandom_range(8, 16));
                end else begin
                    case ($urandom_range(0, 9))
                        0: count_val = 6'd0;
                        1: count_val = CNT_W'($urandom_range(33, 63));
                        2: count_val = CNT_W'($urandom_range(9, 32));
                        default: count_val = CNT_W'($urandom_range(1, 8));
                    endcase
                end
                write_node_count(count_val);
                n = (int'(count_val) < 1) ? 1 :
                    ((int'(count_val) > STORE_ROWS) ? STORE_ROWS : int'(count_val));
            end
            // graph 4 closes while the receiver holds off; graph 5 keeps pushing
            random_graph(n, graph_no == 4);
            graph_no++;
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("covered %0d graphs from %0d loaded rows, %0d closure rows compared",
                 sb.graphs_closed, sb.rows_loaded, sb.rows_checked);
        $display("node counts from zero through 63, random stalls on both sides");
        if (sb.errors == 0) begin
            $display("[bit_matrix_transitive_closure_top] OK");
        end else begin
            $display("[bit_matrix_transitive_closure_top] ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/bmtc_pkg.sv
design/bit_matrix_transitive_closure_top.sv
test/tb_bit_matrix_transitive_closure_top.sv
